### rtl/lrup_pkg.sv
// ----------------------------------------------------------------------------
// lrup_pkg: shared types and constants for LRU page replacement
// Frame store sizing, field widths and the records passed between modules.
// ----------------------------------------------------------------------------
package lrup_pkg;

   localparam int MAX_FRAMES = 8;
   localparam int PAGE_BITS  = 16;
   localparam int IDX_BITS   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_BITS   = $clog2(MAX_FRAMES + 1);
   localparam int CFG_BITS   = 4;
   localparam int FAULT_BITS = 32;

   localparam logic [CFG_BITS-1:0] FRAMES_RESET = 4'd8;

   typedef logic [PAGE_BITS-1:0]  page_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [IDX_BITS-1:0]   rank_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [CFG_BITS-1:0]   cfg_type;
   typedef logic [FAULT_BITS-1:0] fault_type;

   typedef page_type [MAX_FRAMES-1:0] frame_vec_type;
   typedef rank_type [MAX_FRAMES-1:0] rank_vec_type;

   typedef struct packed {
      logic    hit;
      idx_type hit_idx;
      idx_type victim_idx;
   } match_type;

   typedef struct packed {
      logic      page_fault;
      logic      evicted_valid;
      page_type  evicted_page;
      fault_type fault_total;
   } result_type;

endpackage

### rtl/lrup_req_if.sv
// ----------------------------------------------------------------------------
// lrup_req_if: request channel
// Carries one page access and its restart flag.
// ----------------------------------------------------------------------------
interface lrup_req_if import lrup_pkg::*; ();
   logic     valid;
   logic     ready;
   page_type page_number;
   logic     restart;

   modport source (output valid, output page_number, output restart, input ready);
   modport sink   (input valid, input page_number, input restart, output ready);
endinterface

### rtl/lrup_rsp_if.sv
// ----------------------------------------------------------------------------
// lrup_rsp_if: response channel
// Carries the fault, eviction and fault count of one access.
// ----------------------------------------------------------------------------
interface lrup_rsp_if import lrup_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      page_fault;
   logic      evicted_valid;
   page_type  evicted_page;
   fault_type fault_total;

   modport source (output valid, output page_fault, output evicted_valid,
                   output evicted_page, output fault_total, input ready);
   modport sink   (input valid, input page_fault, input evicted_valid,
                   input evicted_page, input fault_total, output ready);
endinterface

### rtl/lrup_csr_if.sv
// ----------------------------------------------------------------------------
// lrup_csr_if: configuration write channel
// Carries the frame capacity register write data.
// ----------------------------------------------------------------------------
interface lrup_csr_if import lrup_pkg::*; ();
   logic    valid;
   logic    ready;
   cfg_type frames_in_use;

   modport source (output valid, output frames_in_use, input ready);
   modport sink   (input valid, input frames_in_use, output ready);
endinterface

### rtl/lrup_match.sv
// ----------------------------------------------------------------------------
// lrup_match: parallel frame lookup
// Compares the page against every occupied frame and finds the LRU frame.
// ----------------------------------------------------------------------------
module lrup_match import lrup_pkg::*; (
   input  page_type      page,
   input  frame_vec_type frames,
   input  rank_vec_type  ranks,
   input  cnt_type       occupied,
   output match_type     result
);

   // Scan downward so the lowest matching frame wins.
   always_comb begin
      result = '0;
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (cnt_type'(i) < occupied) begin
            if (frames[i] == page) begin
               result.hit     = 1'b1;
               result.hit_idx = idx_type'(i);
            end
            if (ranks[i] == '0) begin
               result.victim_idx = idx_type'(i);
            end
         end
      end
   end

endmodule

### rtl/lrup_store.sv
// ----------------------------------------------------------------------------
// lrup_store: frame store and recency state
// Holds pages, ranks, occupancy and fault count; computes one access result.
// ----------------------------------------------------------------------------
module lrup_store import lrup_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       update,
   input  page_type   page,
   input  logic       restart,
   input  cnt_type    capacity,
   output result_type result
);

   frame_vec_type frame_ff, frame_in;
   rank_vec_type  rank_ff, rank_in;
   cnt_type       occ_ff, occ_in;
   fault_type     faults_ff, faults_in;

   rank_vec_type  eff_rank;
   cnt_type       eff_occ;
   fault_type     eff_faults;
   match_type     match;
   rank_type      hit_rank;
   rank_type      top_rank;

   // Restart acts before the lookup.
   always_comb begin
      eff_occ    = restart ? '0 : occ_ff;
      eff_faults = restart ? '0 : faults_ff;
      eff_rank   = restart ? '0 : rank_ff;
   end

   lrup_match u_match (
      .page     (page),
      .frames   (frame_ff),
      .ranks    (eff_rank),
      .occupied (eff_occ),
      .result   (match)
   );

   always_comb begin
      frame_in  = frame_ff;
      rank_in   = eff_rank;
      occ_in    = eff_occ;
      faults_in = eff_faults;
      result    = '0;
      hit_rank  = eff_rank[match.hit_idx];
      top_rank  = rank_type'(eff_occ - cnt_type'(1));
      if (match.hit) begin
         // Promote: frames newer than the hit age by one.
         for (int i = 0; i < MAX_FRAMES; i++) begin
            if (cnt_type'(i) < eff_occ && eff_rank[i] > hit_rank) begin
               rank_in[i] = eff_rank[i] - rank_type'(1);
            end
         end
         rank_in[match.hit_idx] = top_rank;
      end else begin
         result.page_fault = 1'b1;
         if (eff_faults != '1) begin
            faults_in = eff_faults + fault_type'(1);
         end
         if (eff_occ >= capacity) begin
            // Evict LRU frame and reuse it.
            result.evicted_valid = 1'b1;
            result.evicted_page  = frame_ff[match.victim_idx];
            for (int i = 0; i < MAX_FRAMES; i++) begin
               if (cnt_type'(i) < eff_occ && eff_rank[i] != '0) begin
                  rank_in[i] = eff_rank[i] - rank_type'(1);
               end
            end
            frame_in[match.victim_idx] = page;
            rank_in[match.victim_idx]  = top_rank;
         end else begin
            frame_in[eff_occ[IDX_BITS-1:0]] = page;
            rank_in[eff_occ[IDX_BITS-1:0]]  = rank_type'(eff_occ);
            occ_in                           = eff_occ + cnt_type'(1);
         end
      end
      result.fault_total = faults_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff   <= '0;
         occ_ff    <= '0;
         faults_ff <= '0;
      end else if (update) begin
         rank_ff   <= rank_in;
         occ_ff    <= occ_in;
         faults_ff <= faults_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         frame_ff <= frame_in;
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= MAX_FRAMES)
      else $error("occupied count above frame store size");

   a_faults_grow: assert property (@(posedge clock) disable iff (reset)
      update && !restart |=> faults_ff >= $past(faults_ff))
      else $error("fault count dropped without restart");

endmodule

### rtl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement: LRU page replacement over a small frame store
// Takes page accesses, reports faults and evictions, keeps a fault count.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+-----------------------------------------
//   req_ch   | in  | valid/ready  | page_number[15:0], restart
//   rsp_ch   | out | valid/ready  | page_fault, evicted_valid,
//            |     |              | evicted_page[15:0], fault_total[31:0]
//   csr_ch   | in  | valid/ready  | frames_in_use[3:0] (always ready)
//
// One request per clock sustained while the response is taken. A request is
// held in the input register; the lookup, the recency update and the result
// are one pass of logic, and the result is registered in the response
// register, from which it is offered on rsp_ch.
// Synchronous reset clears occupancy, ranks and the fault count and sets
// the capacity to 8; page storage is not reset.
// A stalled response holds; the input register still drains into it when
// the response is taken the same cycle, so a stall costs no bubble.
// ----------------------------------------------------------------------------
module lru_page_replacement import lrup_pkg::*; (
   input  logic clock,
   input  logic reset,
   lrup_req_if.sink   req_ch,
   lrup_rsp_if.source rsp_ch,
   lrup_csr_if.sink   csr_ch
);

   // Input register.
   logic       in_vld_ff, in_vld_in;
   page_type   in_page_ff;
   logic       in_restart_ff;

   // Result register.
   logic       out_vld_ff, out_vld_in;
   result_type out_ff;

   // Capacity register and its clamped value.
   cfg_type    cap_ff;
   cnt_type    capacity;

   result_type result;
   logic       advance;

   // Advance the held request when the result register is free or draining.
   assign advance      = in_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || advance;
   assign csr_ch.ready = 1'b1;

   // Clamp the capacity: zero acts as one, too large acts as the store size.
   always_comb begin
      if (cap_ff == '0) begin
         capacity = cnt_type'(1);
      end else if (32'(cap_ff) > MAX_FRAMES) begin
         capacity = cnt_type'(MAX_FRAMES);
      end else begin
         capacity = cnt_type'(cap_ff);
      end
   end

   lrup_store u_store (
      .clock    (clock),
      .reset    (reset),
      .update   (advance),
      .page     (in_page_ff),
      .restart  (in_restart_ff),
      .capacity (capacity),
      .result   (result)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         cap_ff     <= FRAMES_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_ch.valid && csr_ch.ready) begin
            cap_ff <= csr_ch.frames_in_use;
         end
      end
   end

   // Payload registers: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_page_ff    <= req_ch.page_number;
         in_restart_ff <= req_ch.restart;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid         = out_vld_ff;
   assign rsp_ch.page_fault    = out_ff.page_fault;
   assign rsp_ch.evicted_valid = out_ff.evicted_valid;
   assign rsp_ch.evicted_page  = out_ff.evicted_page;
   assign rsp_ch.fault_total   = out_ff.fault_total;

   a_evict_on_fault: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.evicted_valid |-> out_ff.page_fault)
      else $error("eviction reported without a fault");

   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !out_ff.evicted_valid |-> out_ff.evicted_page == '0)
      else $error("evicted page nonzero with no eviction");

   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.page_fault |-> out_ff.fault_total != '0)
      else $error("fault reported with zero fault count");

endmodule
